// ===== hdl/dbgr_pkg.sv =====
// Shared types, constants and elaboration-time tables of the dB gain ramp smoother.
package dbgr_pkg;

  localparam int DB_W      = 24;
  localparam int RATE_W    = 24;
  localparam int STEP_W    = 16;
  localparam int GAIN_W    = 24;
  localparam int DELTA_W   = RATE_W + STEP_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [RATE_W-1:0]      RATE_RESET    = 24'd179;
  localparam logic signed [DB_W-1:0] FLOOR_RESET   = -24'sd3145728;
  localparam logic signed [DB_W-1:0] CEILING_RESET = 24'sd0;

  localparam logic KIND_SET     = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_RATE  = 2'd0,
    REG_FLOOR_DB   = 2'd1,
    REG_CEILING_DB = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0]      ramp_rate;
    logic signed [DB_W-1:0] floor_db;
    logic signed [DB_W-1:0] ceiling_db;
  } cfg_t;

  typedef struct packed {
    logic signed [DB_W-1:0] level;
    logic                   mute;
  } q_entry_t;

  // log2(10)/20 in Q32.
  localparam int SCALE_W = 31;
  localparam logic signed [SCALE_W-1:0] LOG2_SCALE = 31'sd713378626;
  localparam int PROD_W  = DB_W + SCALE_W;
  localparam int EXP_W   = PROD_W - 32;
  localparam int T_W     = 26;
  localparam int FRAC_W  = 16;
  localparam int MAN_W   = 32;
  localparam int SHIFT_W = 6;
  localparam int ROOT_N  = 16;

  localparam logic signed [T_W-1:0] T_BIAS   = 26'sd1048576;
  localparam logic signed [T_W-1:0] T_SAT    = 26'sd1572864;
  localparam logic signed [T_W-1:0] T_OFFSET = 26'sd4194304;
  localparam int                    SHIFT_MAX = 40;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFFFFFF;
  localparam logic [MAN_W-1:0]  MAN_ONE  = 32'h4000_0000;

  typedef logic [ROOT_N-1:0][MAN_W-1:0] root_tbl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > x) begin
        b = b >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Successive square roots of 2.0 in Q30: entry k holds 2^(2^-(k+1)).
  function automatic root_tbl_t make_roots();
    root_tbl_t   tbl;
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int k = 0; k < ROOT_N; k++) begin
      r = isqrt64(r << 30);
      tbl[k] = r[MAN_W-1:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t ROOT_TBL = make_roots();

endpackage

// ===== hdl/dbgr_if.sv =====
// Handshake channel interfaces for the input items and the result items.
interface dbgr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [dbgr_pkg::DB_W-1:0]    target_db;
  logic [dbgr_pkg::STEP_W-1:0]         step_count;

  modport source (output valid, output kind, output target_db, output step_count,
                  input ready);
  modport sink   (input valid, input kind, input target_db, input step_count,
                  output ready);
endinterface

interface dbgr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dbgr_pkg::DB_W-1:0]    current_db;
  logic [dbgr_pkg::GAIN_W-1:0]         linear_gain;

  modport source (output valid, output current_db, output linear_gain, input ready);
  modport sink   (input valid, input current_db, input linear_gain, output ready);
endinterface

// ===== hdl/db_gain_ramp_smoother_top.sv =====
// Top level of the dB gain ramp smoother: configuration registers, front end, queue, gain engine.
// Each accepted item either sets a new target level, clamped to [floor_db, ceiling_db] with the
// ceiling winning when the limits cross, or advances the current level toward the target by
// ramp_rate * step_count without overshoot; each item yields one result with the current level
// and its gain 10^(dB/20) in unsigned Q8.16, saturating at 0xFFFFFF and zero at the floor.
// The front end takes one item at a time and the gain engine works through pop, product, exponent
// split, 16 mantissa multiply steps and final rounding for each result; the queue between them
// lets the front end accept a new item while the engine is still busy with an earlier one.
// Configuration writes take effect on the next clock and should only be issued while idle.
module db_gain_ramp_smoother_top #(
  parameter int QUEUE_DEPTH = dbgr_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dbgr_in_if.sink                        in_ch,
  dbgr_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [dbgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbgr_pkg::CFG_W-1:0]     cfg_wdata
);

  dbgr_pkg::cfg_t     cfg_r;
  logic               q_push_valid;
  logic               q_push_ready;
  dbgr_pkg::q_entry_t q_push_data;
  logic               q_pop_valid;
  logic               q_pop_ready;
  dbgr_pkg::q_entry_t q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_rate  <= dbgr_pkg::RATE_RESET;
      cfg_r.floor_db   <= dbgr_pkg::FLOOR_RESET;
      cfg_r.ceiling_db <= dbgr_pkg::CEILING_RESET;
    end else if (cfg_we) begin
      case (dbgr_pkg::cfg_reg_t'(cfg_index))
        dbgr_pkg::REG_RAMP_RATE: begin
          cfg_r.ramp_rate <= cfg_wdata;
        end
        dbgr_pkg::REG_FLOOR_DB: begin
          cfg_r.floor_db <= $signed(cfg_wdata);
        end
        dbgr_pkg::REG_CEILING_DB: begin
          cfg_r.ceiling_db <= $signed(cfg_wdata);
        end
        default: begin
        end
      endcase
    end
  end

  dbgr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  dbgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  dbgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_ch    (out_ch)
  );

  // The front end works on one item at a time.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("front end took a second item while busy");

  // A new level that the full queue refuses stays offered unchanged.
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
    else $error("queued level dropped or changed while the queue was full");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_ch.ready && !out_ch.valid)
    else $error("block not idle after reset");

endmodule

// ===== hdl/dbgr_front.sv =====
// Front end: accepts items, clamps targets, ramps the level and queues the new level.
module dbgr_front (
  input  logic               clk,
  input  logic               rst_n,
  dbgr_in_if.sink            in_ch,
  input  dbgr_pkg::cfg_t     cfg,
  output logic               push_valid,
  input  logic               push_ready,
  output dbgr_pkg::q_entry_t push_data
);

  localparam int LVL_W = dbgr_pkg::DELTA_W + 2;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_UPD  = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic                                 kind_r;
  logic signed [dbgr_pkg::DB_W-1:0]     target_r;
  logic [dbgr_pkg::STEP_W-1:0]          steps_r;
  logic [dbgr_pkg::DELTA_W-1:0]         delta_r;
  logic signed [dbgr_pkg::DB_W-1:0]     now_r;
  logic signed [dbgr_pkg::DB_W-1:0]     goal_r;

  logic signed [dbgr_pkg::DB_W-1:0]     clamp_val;
  logic signed [dbgr_pkg::DB_W-1:0]     level_nxt;
  logic signed [LVL_W-1:0]              now_x;
  logic signed [LVL_W-1:0]              goal_x;
  logic signed [LVL_W-1:0]              delta_x;
  logic signed [LVL_W-1:0]              sum_x;
  logic signed [LVL_W-1:0]              diff_x;

  assign in_ch.ready = (state_r == F_IDLE);

  always_comb begin
    clamp_val = target_r;
    if (clamp_val < cfg.floor_db) begin
      clamp_val = cfg.floor_db;
    end
    if (clamp_val > cfg.ceiling_db) begin
      clamp_val = cfg.ceiling_db;
    end
  end

  always_comb begin
    now_x   = LVL_W'(now_r);
    goal_x  = LVL_W'(goal_r);
    delta_x = $signed({2'b00, delta_r});
    sum_x   = now_x + delta_x;
    diff_x  = now_x - delta_x;
    level_nxt = now_r;
    if (kind_r == dbgr_pkg::KIND_ADVANCE) begin
      if (now_x < goal_x) begin
        level_nxt = (sum_x > goal_x) ? goal_r : sum_x[dbgr_pkg::DB_W-1:0];
      end else begin
        level_nxt = (diff_x < goal_x) ? goal_r : diff_x[dbgr_pkg::DB_W-1:0];
      end
    end
  end

  assign push_valid      = (state_r == F_UPD);
  assign push_data.level = level_nxt;
  assign push_data.mute  = (level_nxt == cfg.floor_db);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_UPD;
      end
      F_UPD: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      now_r   <= dbgr_pkg::FLOOR_RESET;
      goal_r  <= dbgr_pkg::FLOOR_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_MUL && kind_r == dbgr_pkg::KIND_SET) begin
        goal_r <= clamp_val;
      end
      if (state_r == F_UPD && push_ready) begin
        now_r <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r   <= in_ch.kind;
      target_r <= in_ch.target_db;
      steps_r  <= in_ch.step_count;
    end
    if (state_r == F_MUL) begin
      delta_r <= cfg.ramp_rate * steps_r;
    end
  end

endmodule

// ===== hdl/dbgr_queue.sv =====
// Small FIFO that carries new levels from the front end to the gain engine.
module dbgr_queue #(
  parameter int DEPTH = dbgr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  dbgr_pkg::q_entry_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output dbgr_pkg::q_entry_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbgr_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/dbgr_back.sv =====
// Gain engine: converts a queued dB level to a linear Q8.16 gain and holds the result.
module dbgr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  dbgr_pkg::q_entry_t pop_data,
  dbgr_out_if.source         out_ch
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_PROD = 5'b00010,
    B_EXP  = 5'b00100,
    B_MAN  = 5'b01000,
    B_FIN  = 5'b10000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic signed [dbgr_pkg::DB_W-1:0]    level_r;
  logic                                mute_r;
  logic signed [dbgr_pkg::PROD_W-1:0]  prod_r;
  logic [dbgr_pkg::FRAC_W-1:0]         frac_r;
  logic [dbgr_pkg::SHIFT_W-1:0]        shift_r;
  logic                                sat_r;
  logic                                zero_r;
  logic [dbgr_pkg::MAN_W-1:0]          man_r;
  logic [$clog2(dbgr_pkg::ROOT_N)-1:0] step_r;

  logic                                out_valid_r;
  logic signed [dbgr_pkg::DB_W-1:0]    out_db_r;
  logic [dbgr_pkg::GAIN_W-1:0]         out_gain_r;

  logic signed [dbgr_pkg::PROD_W-1:0]  prod_rnd;
  logic signed [dbgr_pkg::EXP_W-1:0]   exp_q16;
  logic signed [dbgr_pkg::T_W-1:0]     t_val;
  logic signed [dbgr_pkg::T_W-1:0]     tu_val;
  logic signed [9:0]                   n_val;
  logic signed [9:0]                   s_val;
  logic [63:0]                         man_prod;
  logic [63:0]                         man_rnd;
  logic [63:0]                         gain_full;
  logic [dbgr_pkg::GAIN_W-1:0]         gain_val;
  logic                                slot_free;

  assign pop_ready = (state_r == B_IDLE);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    prod_rnd = prod_r + (dbgr_pkg::PROD_W'(1) <<< 31);
    exp_q16  = prod_rnd[dbgr_pkg::PROD_W-1:32];
    t_val    = dbgr_pkg::T_W'(exp_q16) + dbgr_pkg::T_BIAS;
    tu_val   = t_val + dbgr_pkg::T_OFFSET;
    n_val    = $signed(tu_val[dbgr_pkg::T_W-1:16]) - 10'sd64;
    s_val    = 10'sd30 - n_val;
  end

  always_comb begin
    man_prod = man_r * dbgr_pkg::ROOT_TBL[step_r];
    man_rnd  = (man_prod + 64'h2000_0000) >> 30;
  end

  always_comb begin
    gain_full = ({32'b0, man_r} + (64'd1 << (shift_r - 1'b1))) >> shift_r;
    if (mute_r || zero_r) begin
      gain_val = '0;
    end else if (sat_r || gain_full > 64'(dbgr_pkg::GAIN_MAX)) begin
      gain_val = dbgr_pkg::GAIN_MAX;
    end else begin
      gain_val = gain_full[dbgr_pkg::GAIN_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          state_nxt = B_PROD;
        end
      end
      B_PROD: begin
        state_nxt = B_EXP;
      end
      B_EXP: begin
        state_nxt = B_MAN;
      end
      B_MAN: begin
        if (step_r == '1) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          level_r <= pop_data.level;
          mute_r  <= pop_data.mute;
        end
      end
      B_PROD: begin
        prod_r <= level_r * dbgr_pkg::LOG2_SCALE;
      end
      B_EXP: begin
        sat_r   <= (t_val >= dbgr_pkg::T_SAT);
        zero_r  <= (tu_val < 0) || (s_val > 10'sd40);
        shift_r <= s_val[dbgr_pkg::SHIFT_W-1:0];
        frac_r  <= tu_val[dbgr_pkg::FRAC_W-1:0];
        man_r   <= dbgr_pkg::MAN_ONE;
        step_r  <= '0;
      end
      B_MAN: begin
        if (frac_r[dbgr_pkg::FRAC_W-1]) begin
          man_r <= man_rnd[dbgr_pkg::MAN_W-1:0];
        end
        frac_r <= frac_r << 1;
        step_r <= step_r + 1'b1;
      end
      B_FIN: begin
        if (slot_free) begin
          out_db_r   <= level_r;
          out_gain_r <= gain_val;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.current_db  = out_db_r;
  assign out_ch.linear_gain = out_gain_r;

endmodule

// ===== sim/tb_db_gain_ramp_smoother_top.sv =====
// Self-checking testbench of the dB gain ramp smoother against a level and gain predictor.
module tb_db_gain_ramp_smoother_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 100;

  localparam logic signed [dbgr_pkg::DB_W-1:0] DB_MAX =
    {1'b0, {(dbgr_pkg::DB_W-1){1'b1}}};
  localparam logic signed [dbgr_pkg::DB_W-1:0] DB_MIN =
    {1'b1, {(dbgr_pkg::DB_W-1){1'b0}}};
  localparam logic signed [dbgr_pkg::DB_W-1:0] DB_TOP = 24'sd3145728;
  localparam logic [dbgr_pkg::RATE_W-1:0]      RATE_MAX = {dbgr_pkg::RATE_W{1'b1}};

  typedef struct {
    logic signed [dbgr_pkg::DB_W-1:0] db;
    logic [dbgr_pkg::GAIN_W-1:0]      gain;
  } level_gain_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we;
  logic [dbgr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dbgr_pkg::CFG_W-1:0]     cfg_wdata;

  dbgr_in_if  in_ch ();
  dbgr_out_if out_ch ();

  db_gain_ramp_smoother_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  level_gain_t                      expected_levels[$];
  level_gain_t                      want_lg;
  longint unsigned                  root_q30[dbgr_pkg::ROOT_N];
  logic [dbgr_pkg::RATE_W-1:0]      rate_m;
  logic signed [dbgr_pkg::DB_W-1:0] floor_m;
  logic signed [dbgr_pkg::DB_W-1:0] ceil_m;
  logic signed [dbgr_pkg::DB_W-1:0] now_m;
  logic signed [dbgr_pkg::DB_W-1:0] goal_m;

  int   fail_count = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   reg_writes = 0;
  int   stall_cycles = 0;
  int   rx_wait = 0;
  int   idle_cycles = 0;
  logic calm = 1'b0;

  always #6 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic void build_roots();
    longint unsigned r;
    r = 64'h8000_0000;
    for (int k = 0; k < dbgr_pkg::ROOT_N; k++) begin
      r = int_sqrt(r << 30);
      root_q30[k] = r;
    end
  endfunction

  function automatic logic [dbgr_pkg::GAIN_W-1:0] db_to_q16_gain(
    input logic signed [dbgr_pkg::DB_W-1:0] db
  );
    longint          p;
    longint          e;
    longint          t;
    longint          n;
    longint          s;
    longint unsigned m;
    longint unsigned g;
    logic [15:0]     f;
    p = longint'(db) * longint'(dbgr_pkg::LOG2_SCALE);
    e = (p + 64'sd2147483648) >>> 32;
    t = e + longint'(dbgr_pkg::T_BIAS);
    if (t >= longint'(dbgr_pkg::T_SAT)) begin
      return dbgr_pkg::GAIN_MAX;
    end
    if (t + longint'(dbgr_pkg::T_OFFSET) < 0) begin
      return '0;
    end
    n = t >>> dbgr_pkg::FRAC_W;
    f = t[15:0];
    m = 64'd1 << 30;
    for (int k = 0; k < dbgr_pkg::ROOT_N; k++) begin
      if (f[15-k]) begin
        m = (m * root_q30[k] + (64'd1 << 29)) >> 30;
      end
    end
    if (n >= 0) begin
      g = ((m << n) + (64'd1 << 29)) >> 30;
    end else begin
      s = 30 - n;
      if (s > longint'(dbgr_pkg::SHIFT_MAX)) begin
        g = '0;
      end else begin
        g = (m + (64'd1 << (s - 1))) >> s;
      end
    end
    if (g > 64'hFF_FFFF) begin
      g = 64'hFF_FFFF;
    end
    return g[dbgr_pkg::GAIN_W-1:0];
  endfunction

  function automatic void reset_model();
    rate_m  = dbgr_pkg::RATE_RESET;
    floor_m = dbgr_pkg::FLOOR_RESET;
    ceil_m  = dbgr_pkg::CEILING_RESET;
    now_m   = dbgr_pkg::FLOOR_RESET;
    goal_m  = dbgr_pkg::FLOOR_RESET;
  endfunction

  function automatic void predict_level(input logic kind,
                                        input logic signed [dbgr_pkg::DB_W-1:0] tgt,
                                        input logic [dbgr_pkg::STEP_W-1:0] steps);
    logic signed [dbgr_pkg::DB_W-1:0] clamped;
    longint                           delta;
    longint                           pos;
    level_gain_t                      lg;
    if (kind == dbgr_pkg::KIND_SET) begin
      clamped = tgt;
      if (clamped < floor_m) begin
        clamped = floor_m;
      end
      if (clamped > ceil_m) begin
        clamped = ceil_m;
      end
      goal_m = clamped;
    end else begin
      delta = longint'(rate_m) * longint'(steps);
      pos = longint'(now_m);
      if (now_m < goal_m) begin
        pos = pos + delta;
        if (pos > longint'(goal_m)) begin
          pos = longint'(goal_m);
        end
      end else begin
        pos = pos - delta;
        if (pos < longint'(goal_m)) begin
          pos = longint'(goal_m);
        end
      end
      now_m = pos[dbgr_pkg::DB_W-1:0];
    end
    lg.db   = now_m;
    lg.gain = (now_m == floor_m) ? '0 : db_to_q16_gain(now_m);
    expected_levels.push_back(lg);
  endfunction

  // Receiver: a random wait after each result transfer outside calm runs, plus a long hold when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rx_wait = calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (expected_levels.size() == 0) begin
        $error("unexpected result: current_db %0d, linear_gain %0d",
               out_ch.current_db, out_ch.linear_gain);
        fail_count++;
      end else begin
        want_lg = expected_levels.pop_front();
        if (out_ch.current_db !== want_lg.db) begin
          $error("current_db: expected %0d, actual %0d", want_lg.db, out_ch.current_db);
          fail_count++;
        end
        if (out_ch.linear_gain !== want_lg.gain) begin
          $error("linear_gain: expected %0d, actual %0d", want_lg.gain, out_ch.linear_gain);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic kind, input logic signed [dbgr_pkg::DB_W-1:0] tgt,
                           input logic [dbgr_pkg::STEP_W-1:0] steps);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.target_db  <= tgt;
    in_ch.step_count <= steps;
    do @(posedge clk); while (!in_ch.ready);
    predict_level(kind, tgt, steps);
    items_sent++;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    logic                             kind;
    logic signed [dbgr_pkg::DB_W-1:0] tgt;
    logic [dbgr_pkg::STEP_W-1:0]      steps;
    kind = ($urandom_range(0, 9) < 4) ? dbgr_pkg::KIND_SET : dbgr_pkg::KIND_ADVANCE;
    case ($urandom_range(0, 3))
      0: tgt = dbgr_pkg::DB_W'($urandom);
      1: tgt = dbgr_pkg::DB_W'(floor_m + $urandom_range(0, 524288));
      2: tgt = $urandom_range(0, 1) ? floor_m : ceil_m;
      default: tgt = dbgr_pkg::DB_W'(ceil_m - $urandom_range(0, 1 << 20));
    endcase
    case ($urandom_range(0, 7))
      0: steps = '0;
      1, 2, 3: steps = dbgr_pkg::STEP_W'($urandom_range(1, 64));
      4, 5: steps = dbgr_pkg::STEP_W'($urandom_range(1, 1024));
      default: steps = dbgr_pkg::STEP_W'($urandom);
    endcase
    send_item(kind, tgt, steps);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input dbgr_pkg::cfg_reg_t idx,
                           input logic [dbgr_pkg::CFG_W-1:0] wdata);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dbgr_pkg::REG_RAMP_RATE:  rate_m = wdata;
      dbgr_pkg::REG_FLOOR_DB:   floor_m = wdata;
      dbgr_pkg::REG_CEILING_DB: ceil_m = wdata;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [dbgr_pkg::CFG_W-1:0] rate,
                            input logic [dbgr_pkg::CFG_W-1:0] floor_val,
                            input logic [dbgr_pkg::CFG_W-1:0] ceil_val);
    write_reg(dbgr_pkg::REG_RAMP_RATE, rate);
    write_reg(dbgr_pkg::REG_FLOOR_DB, floor_val);
    write_reg(dbgr_pkg::REG_CEILING_DB, ceil_val);
  endtask

  task automatic test_reset_values();
    send_item(dbgr_pkg::KIND_ADVANCE, DB_MAX, '0);
    send_item(dbgr_pkg::KIND_SET, '0, '0);
    send_item(dbgr_pkg::KIND_ADVANCE, DB_MIN, 16'd1);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'hFFFF);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'hFFFF);
    send_item(dbgr_pkg::KIND_SET, DB_MAX, 16'hFFFF);
    send_item(dbgr_pkg::KIND_SET, DB_MIN, 16'h5555);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'd100);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'hFFFF);
  endtask

  task automatic test_register_extremes();
    set_limits(RATE_MAX, DB_MIN, DB_TOP);
    send_item(dbgr_pkg::KIND_SET, DB_TOP, '0);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'd1);
    send_item(dbgr_pkg::KIND_SET, DB_MIN, '0);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'd1);
    write_reg(dbgr_pkg::REG_RAMP_RATE, 24'd1);
    send_item(dbgr_pkg::KIND_SET, '0, '0);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'hFFFF);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'd1);
  endtask

  // The ceiling wins when the floor lies above it.
  task automatic test_inverted_limits();
    set_limits(dbgr_pkg::RATE_RESET, '0, -24'sd1048576);
    send_item(dbgr_pkg::KIND_SET, DB_MAX, '0);
    send_item(dbgr_pkg::KIND_SET, DB_MIN, '0);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, 16'hFFFF);
  endtask

  // Moving the limits leaves the stored levels where they are.
  task automatic test_limits_moved_later();
    write_reg(dbgr_pkg::REG_FLOOR_DB, now_m);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, '0);
    set_limits(24'd4096, dbgr_pkg::FLOOR_RESET, DB_TOP);
    send_item(dbgr_pkg::KIND_ADVANCE, '0, '0);
  endtask

  task automatic test_backpressure();
    calm <= 1'b1;
    stall_cycles <= HOLD_CYCLES;
    repeat (16) send_random_item();
    calm <= 1'b0;
    wait_drained();
  endtask

  task automatic test_no_idle_run();
    calm <= 1'b1;
    repeat (60) send_random_item();
    calm <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [dbgr_pkg::CFG_W-1:0] rate;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: rate = dbgr_pkg::CFG_W'($urandom_range(1, 64));
        1: rate = dbgr_pkg::CFG_W'($urandom_range(65, 4096));
        2: rate = dbgr_pkg::CFG_W'($urandom_range(1, RATE_MAX));
        default: rate = ph[0] ? 24'd1 : RATE_MAX;
      endcase
      set_limits(rate, dbgr_pkg::CFG_W'(-int'($urandom_range(0, 8388608))),
                 dbgr_pkg::CFG_W'(int'($urandom_range(0, 11534336)) - 8388608));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && ph % 3 == 0) begin
          wait_drained();
        end
        send_random_item();
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.kind       = dbgr_pkg::KIND_SET;
    in_ch.target_db  = '0;
    in_ch.step_count = '0;
    cfg_we           = 1'b0;
    cfg_index        = dbgr_pkg::REG_RAMP_RATE;
    cfg_wdata        = '0;
    build_roots();
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_register_extremes();
    test_inverted_limits();
    test_limits_moved_later();
    test_backpressure();
    test_no_idle_run();
    test_random_phases();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results of %0d set and advance items over %0d register writes,",
             results_checked, items_sent, reg_writes);
    $display("with crossed limits, floor muting, zero ticks and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== db_gain_ramp_smoother_top.f =====
hdl/dbgr_pkg.sv
hdl/dbgr_if.sv
hdl/dbgr_front.sv
hdl/dbgr_queue.sv
hdl/dbgr_back.sv
hdl/db_gain_ramp_smoother_top.sv
sim/tb_db_gain_ramp_smoother_top.sv
